// File: rtl/mts_pkg.sv
// Shared constants, types and codes of the max-tracking stack.
`timescale 1ns / 1ps
package mts_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int FILL_W      = 7;
    localparam int STATUS_W    = 2;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int PTR_W       = $clog2(STACK_DEPTH);

    typedef enum logic {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_HOLD
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // item taken this cycle: apply push or pop
        logic use_rdata;  // memory read of the new top is valid now
        logic load_out;   // capture the result into the output register
    } t_dp_cmd;

endpackage

// File: rtl/mts_in_if.sv
// Input channel of the max-tracking stack: operation and value.
`timescale 1ns / 1ps
interface mts_in_if;
    import mts_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     func;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output func, output push_value, input ready);
    modport sink   (input valid, input func, input push_value, output ready);
endinterface

// File: rtl/mts_out_if.sv
// Result channel of the max-tracking stack.
`timescale 1ns / 1ps
interface mts_out_if;
    import mts_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] max_value;
    logic [FILL_W-1:0]        fill_count;
    logic                     is_empty;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, output top_value, output max_value, output fill_count,
                    output is_empty, output status, input ready);
    modport sink   (input valid, input top_value, input max_value, input fill_count,
                    input is_empty, input status, output ready);
endinterface

// File: rtl/mts_ctrl.sv
// Controller of the max-tracking stack: sequences accept, top refresh and result.
`timescale 1ns / 1ps
module mts_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output mts_pkg::t_dp_cmd o_cmd
);
    import mts_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_in_ready = 1'b0;
        // drop the held result once taken
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                // hold off the input while reset is asserted
                o_in_ready   = i_rst_n;
                o_cmd.accept = i_in_valid && i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.use_rdata = 1'b1;
                o_cmd.load_out  = slot_free;
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                o_cmd.load_out = slot_free;
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/mts_datapath.sv
// Datapath of the max-tracking stack: entry memory, top cache, count and result register.
`timescale 1ns / 1ps
module mts_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mts_pkg::t_dp_cmd                  i_cmd,
    input  logic                              i_func,
    input  logic signed [mts_pkg::DATA_W-1:0] i_push_value,
    output logic signed [mts_pkg::DATA_W-1:0] o_top_value,
    output logic signed [mts_pkg::DATA_W-1:0] o_max_value,
    output logic [mts_pkg::FILL_W-1:0]        o_fill_count,
    output logic                              o_is_empty,
    output logic [mts_pkg::STATUS_W-1:0]      o_status
);
    import mts_pkg::*;

    // each entry holds {value, running max of itself and all below}
    logic [2*DATA_W-1:0] r_mem [STACK_DEPTH];
    logic [2*DATA_W-1:0] r_rdata;

    logic [CNT_W-1:0]         r_count;
    logic signed [DATA_W-1:0] r_top_value;
    logic signed [DATA_W-1:0] r_top_max;
    logic                     r_was_pop;
    t_status                  r_status;

    logic signed [DATA_W-1:0] r_out_top;
    logic signed [DATA_W-1:0] r_out_max;
    logic [FILL_W-1:0]        r_out_fill;
    logic                     r_out_empty;
    t_status                  r_out_status;

    logic                     full;
    logic                     empty;
    logic                     is_pop;
    logic                     do_push;
    logic                     do_pop;
    logic                     refresh;
    logic [PTR_W-1:0]         rd_addr;
    logic signed [DATA_W-1:0] below_max;
    logic signed [DATA_W-1:0] push_max;
    logic signed [DATA_W-1:0] view_top;
    logic signed [DATA_W-1:0] view_max;

    assign full    = (r_count == CNT_W'(STACK_DEPTH));
    assign empty   = (r_count == '0);
    assign is_pop  = (i_func == FUNC_POP);
    assign do_push = i_cmd.accept && !is_pop && !full;
    assign do_pop  = i_cmd.accept && is_pop && !empty;
    assign refresh = i_cmd.use_rdata && r_was_pop;

    // entry that becomes the top after a pop
    assign rd_addr   = PTR_W'(r_count - CNT_W'(2));
    assign below_max = r_top_max;
    assign push_max  = (!empty && (below_max > i_push_value)) ? below_max : i_push_value;

    assign view_top = refresh ? $signed(r_rdata[2*DATA_W-1:DATA_W]) : r_top_value;
    assign view_max = refresh ? $signed(r_rdata[DATA_W-1:0])        : r_top_max;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_count[PTR_W-1:0]] <= {i_push_value, push_max};
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_was_pop <= 1'b0;
            r_status  <= ST_OK;
        end else if (i_cmd.accept) begin
            r_was_pop <= do_pop;
            if (do_push) begin
                r_count  <= r_count + CNT_W'(1);
                r_status <= ST_OK;
            end else if (do_pop) begin
                r_count  <= r_count - CNT_W'(1);
                r_status <= ST_OK;
            end else if (is_pop) begin
                r_status <= ST_UNDERFLOW;
            end else begin
                r_status <= ST_OVERFLOW;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_top_value <= i_push_value;
            r_top_max   <= push_max;
        end else if (refresh) begin
            r_top_value <= view_top;
            r_top_max   <= view_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_top    <= empty ? '0 : view_top;
            r_out_max    <= empty ? '0 : view_max;
            r_out_fill   <= FILL_W'(r_count);
            r_out_empty  <= empty;
            r_out_status <= r_status;
        end
    end

    assign o_top_value  = r_out_top;
    assign o_max_value  = r_out_max;
    assign o_fill_count = r_out_fill;
    assign o_is_empty   = r_out_empty;
    assign o_status     = r_out_status;

endmodule

// File: rtl/max_tracking_stack_unit.sv
// Top level of the max-tracking stack: controller and datapath joined to the channels.
//
// Usage:
//   i_in carries one item per handshake: func (0 push push_value, 1 pop).
//   o_out returns exactly one item per input item: top_value, max_value,
//   fill_count, is_empty and status (0 ok, 1 overflow, 2 underflow).
//   Both channels move an item at a rising edge with valid and ready high.
// Sequencing:
//   An accepted item moves the controller from idle to fetch, where its
//   result is loaded into the output register if o_out is free, else it
//   waits in hold. No new item is taken until that result is loaded; every
//   item passes fetch, where a pop takes its new top from the entry memory read.
// Reset:
//   i_rst_n (synchronous, active low) empties the stack, drops any held
//   result and holds i_in.ready low. The entry memory is not cleared; only
//   filled entries reach the outputs.
// Stall:
//   A finished result waits in the output register while the next item is
//   accepted and worked; that item then holds until the register frees.
//   A push into a full stack or a pop from an empty one leaves it unchanged.
`timescale 1ns / 1ps
module max_tracking_stack_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mts_in_if.sink    i_in,
    mts_out_if.source o_out
);
    import mts_pkg::*;

    t_dp_cmd cmd;
    logic    in_ready;
    logic    out_valid;

    // Sequence: accept, refresh the top from memory, load the result.
    mts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    // Hold the stack, its cached top and the result register.
    mts_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_func       (i_in.func),
        .i_push_value (i_in.push_value),
        .o_top_value  (o_out.top_value),
        .o_max_value  (o_out.max_value),
        .o_fill_count (o_out.fill_count),
        .o_is_empty   (o_out.is_empty),
        .o_status     (o_out.status)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

// File: verif/max_tracking_stack_unit_tb.sv
// Self-checking testbench of the max-tracking stack: directed table, then random episodes.
`timescale 1ns / 1ps
module max_tracking_stack_unit_tb;
    import mts_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 1750;
    localparam int PHASES       = 4;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic signed [DATA_W-1:0] max_value;
        logic [FILL_W-1:0]        fill_count;
        logic                     is_empty;
        t_status                  status;
    } t_stack_view;

    typedef struct packed {
        t_func                    op;
        logic signed [DATA_W-1:0] value;
        logic                     typed;
        t_stack_view              want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mts_in_if  in_ch ();
    mts_out_if out_ch ();

    max_tracking_stack_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow copy of the stack contents and depth.
    logic signed [DATA_W-1:0] shadow_vals  [STACK_DEPTH];
    logic signed [DATA_W-1:0] shadow_maxes [STACK_DEPTH];
    int                       shadow_depth;

    t_stack_view awaited_views[$];
    t_dir_row    dir_rows[$];
    int          mismatch_count = 0;
    int          items_sent     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_requests  = 0;

    // Apply one operation to the shadow stack and return what the block should show.
    function automatic t_stack_view apply_stack_op(t_func op, logic signed [DATA_W-1:0] v);
        t_stack_view view;
        logic signed [DATA_W-1:0] mx;
        view.status = ST_OK;
        if (op == FUNC_PUSH) begin
            if (shadow_depth >= STACK_DEPTH) begin
                view.status = ST_OVERFLOW;
            end else begin
                mx = v;
                if (shadow_depth > 0 && shadow_maxes[shadow_depth-1] > v)
                    mx = shadow_maxes[shadow_depth-1];
                shadow_vals[shadow_depth]  = v;
                shadow_maxes[shadow_depth] = mx;
                shadow_depth++;
            end
        end else begin
            if (shadow_depth == 0)
                view.status = ST_UNDERFLOW;
            else
                shadow_depth--;
        end
        if (shadow_depth > 0) begin
            view.top_value = shadow_vals[shadow_depth-1];
            view.max_value = shadow_maxes[shadow_depth-1];
        end else begin
            view.top_value = '0;
            view.max_value = '0;
        end
        view.fill_count = shadow_depth[FILL_W-1:0];
        view.is_empty   = (shadow_depth == 0);
        return view;
    endfunction

    // Pick a push value: extremes, small values that collide, the current max, or anything.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return $signed($urandom_range(6)) - 3;
            3: return (shadow_depth > 0) ? shadow_maxes[shadow_depth-1] : $signed($urandom());
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic dir_row(t_func op, logic signed [DATA_W-1:0] value, logic typed,
                           logic signed [DATA_W-1:0] top, logic signed [DATA_W-1:0] mx,
                           int fill, logic empty, t_status st);
        t_dir_row row;
        row.op              = op;
        row.value           = value;
        row.typed           = typed;
        row.want.top_value  = top;
        row.want.max_value  = mx;
        row.want.fill_count = fill[FILL_W-1:0];
        row.want.is_empty   = empty;
        row.want.status     = st;
        dir_rows.push_back(row);
    endtask

    // Offer one item after a random gap; hold it until the block takes it.
    task automatic send_item(t_func op, logic signed [DATA_W-1:0] value, logic typed,
                             t_stack_view want);
        t_stack_view predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.func       <= op;
        in_ch.push_value <= value;
        do @(posedge i_clk); while (!in_ch.ready);
        predicted = apply_stack_op(op, value);
        awaited_views.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic send_op(t_func op);
        send_item(op, (op == FUNC_PUSH) ? pick_value() : $signed($urandom()), 1'b0, '0);
    endtask

    // Drop valid and wait until every result has come back.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (awaited_views.size() != 0);
    endtask

    // Receiver: random stalls, plus long hold-offs on request so the input backs up.
    initial begin : receiver
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_stack_view want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (awaited_views.size() == 0) begin
                $error("unexpected result: top_value %0d, fill_count %0d",
                       out_ch.top_value, out_ch.fill_count);
                mismatch_count++;
            end else begin
                want = awaited_views.pop_front();
                if (out_ch.top_value !== want.top_value) begin
                    $error("top_value: expected %0d, actual %0d",
                           want.top_value, out_ch.top_value);
                    mismatch_count++;
                end
                if (out_ch.max_value !== want.max_value) begin
                    $error("max_value: expected %0d, actual %0d",
                           want.max_value, out_ch.max_value);
                    mismatch_count++;
                end
                if (out_ch.fill_count !== want.fill_count) begin
                    $error("fill_count: expected %0d, actual %0d",
                           want.fill_count, out_ch.fill_count);
                    mismatch_count++;
                end
                if (out_ch.is_empty !== want.is_empty) begin
                    $error("is_empty: expected %0d, actual %0d",
                           want.is_empty, out_ch.is_empty);
                    mismatch_count++;
                end
                if (out_ch.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, out_ch.status);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int phase;
        int phase_end;
        int n;
        in_ch.valid      = 1'b0;
        in_ch.func       = FUNC_PUSH;
        in_ch.push_value = '0;
        i_rst_n          = 1'b0;
        shadow_depth     = 0;

        // Directed: underflow, extremes, equal max, then back to empty.
        dir_row(FUNC_POP,  32'sd0,  1'b1, 32'sd0,  32'sd0,  0, 1'b1, ST_UNDERFLOW);
        dir_row(FUNC_PUSH, VAL_MIN, 1'b1, VAL_MIN, VAL_MIN, 1, 1'b0, ST_OK);
        dir_row(FUNC_PUSH, VAL_MAX, 1'b1, VAL_MAX, VAL_MAX, 2, 1'b0, ST_OK);
        dir_row(FUNC_PUSH, VAL_MAX, 1'b1, VAL_MAX, VAL_MAX, 3, 1'b0, ST_OK);
        dir_row(FUNC_PUSH, 32'sd0,  1'b1, 32'sd0,  VAL_MAX, 4, 1'b0, ST_OK);
        dir_row(FUNC_PUSH, -32'sd1, 1'b1, -32'sd1, VAL_MAX, 5, 1'b0, ST_OK);
        dir_row(FUNC_POP,  32'sd0,  1'b1, 32'sd0,  VAL_MAX, 4, 1'b0, ST_OK);
        dir_row(FUNC_POP,  32'sd0,  1'b1, VAL_MAX, VAL_MAX, 3, 1'b0, ST_OK);
        dir_row(FUNC_POP,  32'sd0,  1'b1, VAL_MAX, VAL_MAX, 2, 1'b0, ST_OK);
        dir_row(FUNC_POP,  32'sd0,  1'b1, VAL_MIN, VAL_MIN, 1, 1'b0, ST_OK);
        dir_row(FUNC_POP,  32'sd0,  1'b1, 32'sd0,  32'sd0,  0, 1'b1, ST_OK);
        dir_row(FUNC_POP,  -32'sd1, 1'b1, 32'sd0,  32'sd0,  0, 1'b1, ST_UNDERFLOW);
        dir_row(FUNC_PUSH, 32'sh5555_5555, 1'b0, '0, '0, 0, 1'b0, ST_OK);
        dir_row(FUNC_PUSH, 32'shAAAA_AAAA, 1'b0, '0, '0, 0, 1'b0, ST_OK);
        dir_row(FUNC_PUSH, 32'sd1,         1'b0, '0, '0, 0, 1'b0, ST_OK);
        dir_row(FUNC_PUSH, 32'sh5555_5555, 1'b0, '0, '0, 0, 1'b0, ST_OK);
        dir_row(FUNC_POP,  32'shAAAA_AAAA, 1'b0, '0, '0, 0, 1'b0, ST_OK);
        dir_row(FUNC_POP,  32'sh5555_5555, 1'b0, '0, '0, 0, 1'b0, ST_OK);
        dir_row(FUNC_PUSH, 32'sh7FFF_FFFE, 1'b0, '0, '0, 0, 1'b0, ST_OK);
        dir_row(FUNC_POP,  32'sd0,         1'b0, '0, '0, 0, 1'b0, ST_OK);
        dir_row(FUNC_POP,  32'sd0,         1'b0, '0, '0, 0, 1'b0, ST_OK);
        dir_row(FUNC_POP,  32'sd0,         1'b0, '0, '0, 0, 1'b0, ST_OK);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].op, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
        drain_results();

        // Random episodes: fill past full, drain past empty, or a mixed run.
        phase_end = items_sent;
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 57; end
                default: begin send_idle_pct = 27; recv_stall_pct <= 27; end
            endcase
            if (phase == 0 || phase == 2)
                hold_requests <= hold_requests + 1;
            phase_end += RANDOM_ITEMS / PHASES;
            while (items_sent < phase_end) begin
                case ($urandom_range(9))
                    0, 1, 2: begin
                        while (shadow_depth < STACK_DEPTH) send_op(FUNC_PUSH);
                        repeat ($urandom_range(4, 1)) send_op(FUNC_PUSH);
                    end
                    3, 4: begin
                        while (shadow_depth > 0) send_op(FUNC_POP);
                        repeat ($urandom_range(4, 1)) send_op(FUNC_POP);
                    end
                    default: begin
                        n = $urandom_range(50, 10);
                        repeat (n) send_op(($urandom_range(99) < 55) ? FUNC_PUSH : FUNC_POP);
                    end
                endcase
            end
            // Pause the sender until the block has returned everything.
            drain_results();
        end

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_views.size() == 0)
            $display("max_tracking_stack_unit verification clean");
        else
            $display("max_tracking_stack_unit verification failed");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("max_tracking_stack_unit verification failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/mts_pkg.sv
rtl/mts_in_if.sv
rtl/mts_out_if.sv
rtl/mts_ctrl.sv
rtl/mts_datapath.sv
rtl/max_tracking_stack_unit.sv
verif/max_tracking_stack_unit_tb.sv
